// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on aclk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/lifo_sem_pkg.sv -----
// ---------------------------------------------------------------------------
// lifo_sem_pkg
// Constants, codes and controller/datapath interface types of the
// LIFO-wakeup counting semaphore.
// ---------------------------------------------------------------------------
package lifo_sem_pkg;

    // Sizes
    localparam int MAX_WAITERS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NUM_IDS     = 16;
    localparam int ID_W        = 4;
    localparam int ACT_W       = 2;
    localparam int CNT_W       = 16;
    localparam int OC_W        = 3;
    localparam int PEND_W      = 32;
    localparam int FILL_W      = $clog2(MAX_WAITERS + 1);
    localparam int IDX_W       = $clog2(MAX_WAITERS);
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WAIT    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

    // Outcome codes
    localparam logic [OC_W-1:0] OC_GRANTED     = 3'd0;
    localparam logic [OC_W-1:0] OC_QUEUED      = 3'd1;
    localparam logic [OC_W-1:0] OC_WOKEN       = 3'd2;
    localparam logic [OC_W-1:0] OC_TIMED_OUT   = 3'd3;
    localparam logic [OC_W-1:0] OC_NOT_WAITING = 3'd4;
    localparam logic [OC_W-1:0] OC_REJECTED    = 3'd5;
    localparam logic [OC_W-1:0] OC_ABSORBED    = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic prep;      // work out the wake count of a release
        logic exec;      // apply the operation, load the first result
        logic pop;       // pop the next waiter of a release
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic more;      // wakes still to deliver after the current result
    } dp_status_t;

endpackage

// ----- rtl/core/lifo_semaphore_waiter_stack.sv -----
// Counting semaphore with newest-first wakeup. One transaction is taken at a
// time: accept, size a release, apply the operation, then the result stands
// in the output register until taken. A wait, timeout or absorbed release
// gives a single result; a release that wakes N waiters gives N wake results,
// one per cycle while m_tready is high, set by the single pop port on the
// waiter stack. s_tready is low from acceptance until the last result of that
// transaction is taken. Every wake result of a release carries the final
// pending count.
// ---------------------------------------------------------------------------
// lifo_semaphore_waiter_stack
// Top level: stream ports, controller and datapath, assertions.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_semaphore_waiter_stack (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [3:0] waiter_id, [19:4] release_count, [23:20] zero
    input  logic [lifo_sem_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] action
    input  logic [lifo_sem_pkg::ACT_W-1:0]          s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [3:0] result_waiter, [35:4] pending_now, [39:36] zero
    output logic [lifo_sem_pkg::M_TDATA_W-1:0]      m_tdata,
    // [2:0] outcome
    output logic [lifo_sem_pkg::OC_W-1:0]           m_tuser,
    output logic                                    m_tlast
);

    lifo_sem_pkg::dp_cmd_t         cmd;
    lifo_sem_pkg::dp_status_t      status;
    logic [lifo_sem_pkg::ID_W-1:0]   out_waiter;
    logic [lifo_sem_pkg::PEND_W-1:0] out_pending;

    lifo_sem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lifo_sem_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_action        (s_tuser),
        .in_waiter_id     (s_tdata[3:0]),
        .in_release_count (s_tdata[19:4]),
        .out_outcome      (m_tuser),
        .out_waiter       (out_waiter),
        .out_pending      (out_pending),
        .out_last         (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {4'b0, out_pending, out_waiter};

    // Assertions
    `ASSERT_ALWAYS(a_one_at_a_time, !(s_tready && m_tvalid), "input open while result pending")
    `ASSERT_NEXT(a_accept_closes, s_tvalid && s_tready, !s_tready, "input stays open after accept")
    `ASSERT_IMPLY(a_last_matches, m_tvalid, m_tlast == !status.more, "tlast disagrees with wakes left")
    `ASSERT_NEXT(a_more_follows, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tuser == lifo_sem_pkg::OC_WOKEN, "wake result missing")

endmodule

// ----- rtl/core/lifo_sem_ctrl.sv -----
// ---------------------------------------------------------------------------
// lifo_sem_ctrl
// Sequencer: accept one transaction, prepare, execute, then hand out its
// results one per output transaction.
// ---------------------------------------------------------------------------
module lifo_sem_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output lifo_sem_pkg::dp_cmd_t   cmd,
    input  lifo_sem_pkg::dp_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_SEND = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (status.more) begin
                        cmd.pop = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/lifo_sem_dp.sv -----
// ---------------------------------------------------------------------------
// lifo_sem_dp
// Datapath: waiter stack, waiting flags, fill and pending counters, and the
// result register.
// ---------------------------------------------------------------------------
module lifo_sem_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lifo_sem_pkg::dp_cmd_t               cmd,
    output lifo_sem_pkg::dp_status_t            status,
    input  logic [lifo_sem_pkg::ACT_W-1:0]      in_action,
    input  logic [lifo_sem_pkg::ID_W-1:0]       in_waiter_id,
    input  logic [lifo_sem_pkg::CNT_W-1:0]      in_release_count,
    output logic [lifo_sem_pkg::OC_W-1:0]       out_outcome,
    output logic [lifo_sem_pkg::ID_W-1:0]       out_waiter,
    output logic [lifo_sem_pkg::PEND_W-1:0]     out_pending,
    output logic                                out_last
);

    localparam int MW = lifo_sem_pkg::MAX_WAITERS;
    localparam int FW = lifo_sem_pkg::FILL_W;
    localparam int IW = lifo_sem_pkg::IDX_W;
    localparam int CW = lifo_sem_pkg::CNT_W;
    localparam int PW = lifo_sem_pkg::PEND_W;

    // Captured transaction
    logic [lifo_sem_pkg::ACT_W-1:0] action_reg;
    logic [lifo_sem_pkg::ID_W-1:0]  id_reg;
    logic [CW-1:0]                  count_reg;

    // Semaphore state
    logic [lifo_sem_pkg::ID_W-1:0]    stack_mem [MW];
    logic [FW-1:0]                    fill_reg, fill_next;
    logic [lifo_sem_pkg::NUM_IDS-1:0] waiting_reg, waiting_next;
    logic [PW-1:0]                    pending_reg, pending_next;

    // Release bookkeeping
    logic [FW-1:0] wakes_reg, wakes_next;
    logic [FW-1:0] remain_reg, remain_next;

    // Result register
    logic [lifo_sem_pkg::OC_W-1:0] oc_reg, oc_next;
    logic [lifo_sem_pkg::ID_W-1:0] who_reg, who_next;
    logic [PW-1:0]                 pend_out_reg;
    logic                          last_reg;
    logic                          load_out;

    // Helpers
    logic [CW-1:0]                 lim;
    logic [CW-1:0]                 wakes16;
    logic [CW-1:0]                 leftover;
    logic [PW:0]                   pend_sum;
    logic [IW-1:0]                 top_idx;
    logic [IW-1:0]                 push_idx;
    logic [lifo_sem_pkg::ID_W-1:0] top_id;
    logic [MW-1:0]                 match;
    logic [MW-1:0]                 at_or_above;
    logic                          found;
    logic                          do_push;
    logic                          do_shift;
    logic                          do_pop;

    assign top_idx  = IW'(fill_reg - FW'(1));
    assign push_idx = fill_reg[IW-1:0];
    assign top_id   = stack_mem[top_idx];

    // Wake count of a release: min(count, fill, MAX_RESULTS)
    always_comb begin
        if (CW'(fill_reg) < CW'(lifo_sem_pkg::MAX_RESULTS)) begin
            lim = CW'(fill_reg);
        end else begin
            lim = CW'(lifo_sem_pkg::MAX_RESULTS);
        end
        wakes16    = (count_reg < lim) ? count_reg : lim;
        wakes_next = FW'(wakes16);
    end

    // Timeout search: ids on the stack are unique, so at most one match
    always_comb begin
        for (int j = 0; j < MW; j++) begin
            match[j] = (FW'(j) < fill_reg) && (stack_mem[j] == id_reg);
        end
        found       = |match;
        at_or_above = ~(match - MW'(1));
    end

    // Saturating add of the leftover count
    assign leftover = count_reg - CW'(wakes_reg);
    assign pend_sum = {1'b0, pending_reg} + (PW + 1)'(leftover);

    // Operation decode
    always_comb begin
        fill_next    = fill_reg;
        waiting_next = waiting_reg;
        pending_next = pending_reg;
        remain_next  = remain_reg;
        oc_next      = oc_reg;
        who_next     = who_reg;
        do_push      = 1'b0;
        do_shift     = 1'b0;
        do_pop       = 1'b0;
        load_out     = 1'b0;
        if (cmd.exec) begin
            load_out = 1'b1;
            who_next = id_reg;
            unique case (action_reg)
                lifo_sem_pkg::ACT_WAIT: begin
                    if (pending_reg != '0) begin
                        pending_next = pending_reg - PW'(1);
                        oc_next      = lifo_sem_pkg::OC_GRANTED;
                    end else if (waiting_reg[id_reg] || fill_reg == FW'(MW)) begin
                        oc_next = lifo_sem_pkg::OC_REJECTED;
                    end else begin
                        do_push               = 1'b1;
                        fill_next             = fill_reg + FW'(1);
                        waiting_next[id_reg]  = 1'b1;
                        oc_next               = lifo_sem_pkg::OC_QUEUED;
                    end
                end
                lifo_sem_pkg::ACT_RELEASE: begin
                    if (fill_reg == wakes_reg) begin
                        pending_next = pend_sum[PW] ? '1 : pend_sum[PW-1:0];
                    end
                    if (wakes_reg == '0) begin
                        oc_next  = lifo_sem_pkg::OC_ABSORBED;
                        who_next = '0;
                    end else begin
                        do_pop      = 1'b1;
                        remain_next = wakes_reg - FW'(1);
                    end
                end
                lifo_sem_pkg::ACT_TIMEOUT: begin
                    if (found) begin
                        do_shift             = 1'b1;
                        fill_next            = fill_reg - FW'(1);
                        waiting_next[id_reg] = 1'b0;
                        oc_next              = lifo_sem_pkg::OC_TIMED_OUT;
                    end else begin
                        oc_next = lifo_sem_pkg::OC_NOT_WAITING;
                    end
                end
                default: begin
                    oc_next = lifo_sem_pkg::OC_REJECTED;
                end
            endcase
        end else if (cmd.pop) begin
            load_out    = 1'b1;
            do_pop      = 1'b1;
            remain_next = remain_reg - FW'(1);
        end
        // Pop the newest waiter
        if (do_pop) begin
            fill_next            = fill_reg - FW'(1);
            waiting_next[top_id] = 1'b0;
            oc_next              = lifo_sem_pkg::OC_WOKEN;
            who_next             = top_id;
        end
    end

    // Waiter stack: push at the fill point, close the gap on a timeout
    always_ff @(posedge aclk) begin
        for (int j = 0; j < MW - 1; j++) begin
            if (do_shift && at_or_above[j]) begin
                stack_mem[j] <= stack_mem[j + 1];
            end
        end
        if (do_push) begin
            stack_mem[push_idx] <= id_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            waiting_reg <= '0;
            pending_reg <= '0;
            remain_reg  <= '0;
        end else begin
            fill_reg    <= fill_next;
            waiting_reg <= waiting_next;
            pending_reg <= pending_next;
            remain_reg  <= remain_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= in_action;
            id_reg     <= in_waiter_id;
            count_reg  <= in_release_count;
        end
        if (cmd.prep) begin
            wakes_reg <= wakes_next;
        end
        if (load_out) begin
            oc_reg       <= oc_next;
            who_reg      <= who_next;
            pend_out_reg <= pending_next;
            last_reg     <= (remain_next == '0);
        end
    end

    assign status.more = (remain_reg != '0);
    assign out_outcome = oc_reg;
    assign out_waiter  = who_reg;
    assign out_pending = pend_out_reg;
    assign out_last    = last_reg;

endmodule

// ----- dv/lifo_semaphore_waiter_stack_checker.sv -----
// ---------------------------------------------------------------------------
// lifo_semaphore_waiter_stack_checker
// Watches both stream channels of the LIFO-wakeup semaphore. It keeps its own
// copy of the waiter stack, the waiting flags and the pending count, works out
// the results of each accepted input transaction, and compares every accepted
// result transaction, field by field, with the oldest result still owed.
// ---------------------------------------------------------------------------
module lifo_semaphore_waiter_stack_checker
    import lifo_sem_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    // [3:0] waiter_id, [19:4] release_count, [23:20] zero
    input  logic [S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]        s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    // [3:0] result_waiter, [35:4] pending_now, [39:36] zero
    input  logic [M_TDATA_W-1:0]    m_tdata,
    // [2:0] outcome
    input  logic [OC_W-1:0]         m_tuser,
    input  logic                    m_tlast,
    output int                      fail_count,
    output int                      results_due
);

    typedef struct {
        logic [OC_W-1:0]   outcome;
        logic [ID_W-1:0]   waiter;
        logic [PEND_W-1:0] pending;
        logic              last;
    } sem_result_t;

    // Mirror of the semaphore state
    logic [ID_W-1:0]   mirror_stack [MAX_WAITERS];
    int                mirror_fill;
    logic [NUM_IDS-1:0] mirror_waiting;
    logic [PEND_W-1:0] mirror_pending;

    sem_result_t owed_outcomes [$];
    sem_result_t head;

    // One line per mismatch; the log is capped, the count is not
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40) begin
            $display("%0t checker: %s", $time, msg);
        end
    endtask

    // Every result carries the pending count as it stands after the transaction
    function automatic void owe_outcome(input logic [OC_W-1:0] oc,
                                        input logic [ID_W-1:0] who,
                                        input logic            fin);
        sem_result_t r;
        r.outcome = oc;
        r.waiter  = who;
        r.pending = mirror_pending;
        r.last    = fin;
        owed_outcomes.push_back(r);
    endfunction

    // Apply one semaphore operation to the mirror and queue its results
    task automatic step_semaphore(input logic [ACT_W-1:0] act,
                                  input logic [ID_W-1:0]  id,
                                  input logic [CNT_W-1:0] cnt);
        logic [ID_W-1:0]   woken [$];
        logic [PEND_W-1:0] left;
        logic [ID_W-1:0]   top_id;
        int                hit;
        int                i;
        int                k;
        left = {{(PEND_W-CNT_W){1'b0}}, cnt};
        case (act)
            ACT_WAIT: begin
                if (mirror_pending != '0) begin
                    mirror_pending = mirror_pending - 1'b1;
                    owe_outcome(OC_GRANTED, id, 1'b1);
                end else if (mirror_waiting[id] || mirror_fill >= MAX_WAITERS) begin
                    owe_outcome(OC_REJECTED, id, 1'b1);
                end else begin
                    mirror_stack[mirror_fill] = id;
                    mirror_fill++;
                    mirror_waiting[id] = 1'b1;
                    owe_outcome(OC_QUEUED, id, 1'b1);
                end
            end
            ACT_RELEASE: begin
                // newest waiters first, one signal each
                while (left != '0 && mirror_fill > 0 && woken.size() < MAX_RESULTS) begin
                    mirror_fill--;
                    top_id = mirror_stack[mirror_fill];
                    mirror_waiting[top_id] = 1'b0;
                    woken.push_back(top_id);
                    left = left - 1'b1;
                end
                // leftover only counts once the stack is empty; saturate
                if (mirror_fill == 0) begin
                    if (left > ~mirror_pending) mirror_pending = '1;
                    else mirror_pending = mirror_pending + left;
                end
                if (woken.size() == 0) begin
                    owe_outcome(OC_ABSORBED, '0, 1'b1);
                end else begin
                    for (k = 0; k < woken.size(); k++) begin
                        owe_outcome(OC_WOKEN, woken[k], k == woken.size() - 1);
                    end
                end
            end
            ACT_TIMEOUT: begin
                hit = -1;
                for (i = 0; i < mirror_fill; i++) begin
                    if (hit < 0 && mirror_stack[i] == id) hit = i;
                end
                if (hit >= 0) begin
                    // close the gap left by the removed waiter
                    for (i = hit; i + 1 < mirror_fill; i++) begin
                        mirror_stack[i] = mirror_stack[i+1];
                    end
                    mirror_fill--;
                    mirror_waiting[id] = 1'b0;
                    owe_outcome(OC_TIMED_OUT, id, 1'b1);
                end else begin
                    owe_outcome(OC_NOT_WAITING, id, 1'b1);
                end
            end
            default: begin
                owe_outcome(OC_REJECTED, id, 1'b1);
            end
        endcase
    endtask

    // Results are checked before the new transaction is predicted: a result
    // taken at the same edge always belongs to an earlier transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (mirror_stack[i]) mirror_stack[i] = '0;
            mirror_fill    = 0;
            mirror_waiting = '0;
            mirror_pending = '0;
            owed_outcomes.delete();
            fail_count     = 0;
            results_due    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed: outcome %0d waiter %0d",
                                              m_tuser, m_tdata[3:0]));
                end else begin
                    head = owed_outcomes.pop_front();
                    if (m_tuser !== head.outcome)
                        report_mismatch($sformatf("outcome %0d, want %0d (waiter %0d)",
                                                  m_tuser, head.outcome, head.waiter));
                    if (m_tdata[3:0] !== head.waiter)
                        report_mismatch($sformatf("result_waiter %0d, want %0d",
                                                  m_tdata[3:0], head.waiter));
                    if (m_tdata[35:4] !== head.pending)
                        report_mismatch($sformatf("pending_now %h, want %h",
                                                  m_tdata[35:4], head.pending));
                    if (m_tdata[39:36] !== 4'd0)
                        report_mismatch($sformatf("tdata pad bits %h, want 0",
                                                  m_tdata[39:36]));
                    if (m_tlast !== head.last)
                        report_mismatch($sformatf("tlast %b, want %b (waiter %0d)",
                                                  m_tlast, head.last, head.waiter));
                end
            end
            if (s_tvalid && s_tready) begin
                step_semaphore(s_tuser, s_tdata[3:0], s_tdata[19:4]);
            end
            results_due = owed_outcomes.size();
        end
    end

endmodule

// ----- dv/lifo_semaphore_waiter_stack_tb.sv -----
// ---------------------------------------------------------------------------
// lifo_semaphore_waiter_stack_tb
// Drives wait, release, timeout and unknown operations into the semaphore,
// stalls the result channel at random, and leaves checking to the checker.
// A short directed run covers the corner cases, then random bursts of waits
// closed by releases, and last a few maximal releases and grants on a large
// pending count.
// ---------------------------------------------------------------------------
module lifo_semaphore_waiter_stack_tb;
    import lifo_sem_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RUN_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 32;
    // action code with no operation behind it
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [ACT_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [OC_W-1:0]      m_tuser;
    logic                 m_tlast;

    int check_fails;
    int results_due;
    // no idling on either side while set
    bit steady = 1'b0;

    always #(CLK_PERIOD/2) aclk = ~aclk;

    lifo_semaphore_waiter_stack u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lifo_semaphore_waiter_stack_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (check_fails),
        .results_due (results_due)
    );

    // Result side: random back-pressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 36);
    end

    // Offer one operation and hold it until the transaction is taken
    task automatic offer_op(input logic [ACT_W-1:0] act,
                            input logic [ID_W-1:0]  id,
                            input logic [CNT_W-1:0] cnt);
        while (!steady && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'd0, cnt, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int n;
        int burst;
        int pick;
        int k;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty-stack release, stray timeout, unknown action
        offer_op(ACT_RELEASE, 4'd0, 16'd0);
        offer_op(ACT_TIMEOUT, 4'd9, 16'd0);
        offer_op(ACT_UNKNOWN, 4'd15, 16'd0);
        // fill the stack, then a duplicate wait on a full stack
        for (k = 0; k < MAX_WAITERS; k++) offer_op(ACT_WAIT, ID_W'(k), 16'd0);
        offer_op(ACT_WAIT, 4'd7, 16'd0);
        // timeouts at the bottom, the top and the middle of the stack
        offer_op(ACT_TIMEOUT, 4'd0, 16'd0);
        offer_op(ACT_TIMEOUT, 4'd15, 16'd0);
        offer_op(ACT_TIMEOUT, 4'd8, 16'd0);
        // wake all 13, leftover of 3 goes to pending, then grants drain it
        offer_op(ACT_RELEASE, 4'd0, 16'd16);
        offer_op(ACT_WAIT, 4'd3, 16'd0);
        offer_op(ACT_WAIT, 4'd4, 16'd0);
        offer_op(ACT_WAIT, 4'd5, 16'd0);

        // Random: mostly bursts of waits closed by a release, some noise
        n = 0;
        while (n < 95) begin
            steady = (n >= 40 && n < 70);
            pick = $urandom_range(99);
            if (pick < 70) begin
                burst = (pick < 10) ? $urandom_range(12, 20) : $urandom_range(1, 10);
                repeat (burst) begin
                    offer_op(ACT_WAIT, ID_W'($urandom_range(15)), CNT_W'($urandom));
                    n++;
                end
                repeat ($urandom_range(0, 2)) begin
                    offer_op(ACT_TIMEOUT, ID_W'($urandom_range(15)), CNT_W'($urandom));
                    n++;
                end
                offer_op(ACT_RELEASE, ID_W'($urandom_range(15)),
                         CNT_W'($urandom_range(0, burst + 2)));
                n++;
            end else begin
                k = $urandom_range(3);
                if (k == ACT_RELEASE) begin
                    offer_op(ACT_RELEASE, ID_W'($urandom_range(15)),
                             CNT_W'($urandom_range(0, 3)));
                end else begin
                    offer_op(ACT_W'(k), ID_W'($urandom_range(15)), CNT_W'($urandom));
                end
                n++;
            end
        end

        // Large pending count: maximal releases, then small releases, grants, a timeout and an unknown action
        steady = 1'b1;
        repeat (2) offer_op(ACT_RELEASE, ID_W'($urandom_range(15)), 16'hFFFF);
        offer_op(ACT_RELEASE, 4'd2, 16'd1);
        offer_op(ACT_RELEASE, 4'd2, 16'd0);
        offer_op(ACT_WAIT, 4'd6, 16'd0);
        offer_op(ACT_WAIT, 4'd6, 16'd0);
        offer_op(ACT_TIMEOUT, 4'd6, 16'd0);
        offer_op(ACT_UNKNOWN, 4'd1, 16'hFFFF);
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // Drain: every owed result, then a wait for stragglers
        while (results_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (check_fails == 0 && results_due == 0) begin
            $display("lifo_semaphore_waiter_stack_tb: done, clean");
        end else begin
            $display("lifo_semaphore_waiter_stack_tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #RUN_LIMIT;
        $display("lifo_semaphore_waiter_stack_tb: done, errors");
        $finish;
    end

endmodule
